[hdl/clr_pkg.sv]
// ----------------------------------------------------------------------------
// clr_pkg
// shared types, fixed-point coefficients and helpers for the color correction
// ----------------------------------------------------------------------------
package clr_pkg;

  localparam int COEF_FRAC_BITS = 16;
  localparam int ACC_W          = COEF_FRAC_BITS + 12;
  localparam int INT_W          = ACC_W - COEF_FRAC_BITS;
  localparam int CURVE_DEPTH    = 256;

  // item kinds carried in tuser
  localparam logic [1:0] MODE_QUAD  = 2'd0;
  localparam logic [1:0] MODE_BGR   = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;
  localparam logic [1:0] MODE_RSVD  = 2'd3;

  // curve selector of a table write
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;
  localparam logic [1:0] CH_RSVD  = 2'd3;

  typedef logic signed [ACC_W-1:0] acc_t;

  // rounded-to-nearest fixed-point constants
  localparam acc_t K_R_CR = ACC_W'(((longint'(1402)   << COEF_FRAC_BITS) + 500)    / 1000);
  localparam acc_t K_G_CB = ACC_W'(((longint'(344136) << COEF_FRAC_BITS) + 500000) / 1000000);
  localparam acc_t K_G_CR = ACC_W'(((longint'(714136) << COEF_FRAC_BITS) + 500000) / 1000000);
  localparam acc_t K_B_CB = ACC_W'(((longint'(1772)   << COEF_FRAC_BITS) + 500)    / 1000);
  localparam acc_t K_Y_R  = ACC_W'(((longint'(299)    << COEF_FRAC_BITS) + 500)    / 1000);
  localparam acc_t K_Y_G  = ACC_W'(((longint'(587)    << COEF_FRAC_BITS) + 500)    / 1000);
  localparam acc_t K_Y_B  = ACC_W'(((longint'(114)    << COEF_FRAC_BITS) + 500)    / 1000);
  localparam acc_t K_CB_R = ACC_W'(((longint'(168736) << COEF_FRAC_BITS) + 500000) / 1000000);
  localparam acc_t K_CB_G = ACC_W'(((longint'(331264) << COEF_FRAC_BITS) + 500000) / 1000000);
  localparam acc_t K_CR_G = ACC_W'(((longint'(418688) << COEF_FRAC_BITS) + 500000) / 1000000);
  localparam acc_t K_CR_B = ACC_W'(((longint'(81312)  << COEF_FRAC_BITS) + 500000) / 1000000);
  localparam acc_t K_HALF = ACC_W'(longint'(1) << (COEF_FRAC_BITS - 1));
  localparam acc_t K_128  = ACC_W'(longint'(128) << COEF_FRAC_BITS);

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] sample_a;
    logic [7:0] sample_b;
    logic [7:0] sample_c;
    logic [7:0] sample_d;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
    logic [1:0] table_channel;
    logic [7:0] table_index;
  } item_t;

  // chroma products shared by the four luma lanes and the average
  typedef struct packed {
    acc_t r_cr;
    acc_t g_cb;
    acc_t g_cr;
    acc_t b_cb;
  } chroma_t;

  // one curve write
  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    logic [7:0] data;
  } curve_wr_t;

  // floor to integer, then clamp to 0..255
  function automatic logic [7:0] fix_u8(acc_t v);
    logic signed [INT_W-1:0] i;
    i = INT_W'(v >>> COEF_FRAC_BITS);
    if (i < 0) return 8'd0;
    else if (i > INT_W'(255)) return 8'd255;
    else return i[7:0];
  endfunction

  // constant times an unsigned 8-bit level
  function automatic acc_t mul_u8(acc_t k, logic [7:0] u);
    acc_t ue;
    ue = acc_t'({{(ACC_W-8){1'b0}}, u});
    return acc_t'(k * ue);
  endfunction

  function automatic acc_t y_shift(logic [7:0] y);
    acc_t ye;
    ye = acc_t'({{(ACC_W-8){1'b0}}, y});
    return acc_t'(ye <<< COEF_FRAC_BITS);
  endfunction

endpackage

[hdl/ycbcr420_bgr_color_correction.sv]
// ----------------------------------------------------------------------------
// ycbcr420_bgr_color_correction
// curve-based color correction of 4:2:0 luma quads and bgr pixels
// ----------------------------------------------------------------------------
// usage:
//  - s_axis carries one word per cycle while ready; tuser is the kind: quad,
//    bgr pixel or curve write. a curve write loads one entry of the red, green
//    or blue curve and gives no output word; kind 3 is dropped the same way
//  - m_axis gives one word per quad or bgr pixel, in input order
//  - cfg channel writes the enable bit (always ready); write it only while
//    the pipeline is empty. with enable low pixels pass through unchanged
//  - six register stages: input, chroma products, luma curve read, luma
//    rebuild, average curve read, output. a result passes them in that order
//    to m_axis; one word per cycle is sustained while m_axis_tready is high,
//    as there is one read copy of each curve per lookup site
//  - each stage moves when it is empty or the stage after it moves, so
//    bubbles collapse and words keep entering while a result waits
//  - reset clears valid bits and the enable; curves are undefined until
//    software writes them, and no clearing pass is run
// ----------------------------------------------------------------------------
module ycbcr420_bgr_color_correction (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // sample_a, sample_b, sample_c, sample_d, chroma_blue, chroma_red,
  // table_channel, table_index, zero pad
  input  logic [63:0] s_axis_tdata,
  // mode
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_a, out_b, out_c, out_d, out_cb, out_cr
  output logic [47:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);
  import clr_pkg::*;

  logic en_q;

  item_t in_w;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  item_t p1_q, p2_q, p3_q, p4_q, p5_q;
  chroma_t k2_d, k2_q, k3_q, k4_q;
  logic [3:0][7:0] y4_d, y4_q, y5_q;
  logic [2:0][7:0] bgr4_q, bgr5_q;  // blue, green, red
  logic [47:0] out_d, out_q;

  logic [3:0][7:0] ys2;
  logic [3:0][7:0] addr_r, addr_g, addr_b;
  logic [3:0][7:0] data_r, data_g, data_b;
  logic [7:0] avg_addr_r, avg_addr_g, avg_addr_b;
  logic [7:0] avg_r, avg_g, avg_b;
  logic [9:0] ysum4;
  logic [7:0] yavg4;
  curve_wr_t luma_wr_r, luma_wr_g, luma_wr_b;
  curve_wr_t avg_wr_r, avg_wr_g, avg_wr_b;
  logic luma_write, avg_write;
  acc_t cb_acc, cr_acc;

  // enable register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b0;
    end else if (cfg_valid_i) begin
      en_q <= cfg_data_i;
    end
  end

  assign in_w.mode          = s_axis_tuser;
  assign in_w.sample_a      = s_axis_tdata[7:0];
  assign in_w.sample_b      = s_axis_tdata[15:8];
  assign in_w.sample_c      = s_axis_tdata[23:16];
  assign in_w.sample_d      = s_axis_tdata[31:24];
  assign in_w.chroma_blue   = s_axis_tdata[39:32];
  assign in_w.chroma_red    = s_axis_tdata[47:40];
  assign in_w.table_channel = s_axis_tdata[49:48];
  assign in_w.table_index   = s_axis_tdata[57:50];

  // per-stage move enables, bubbles collapse
  assign rdy6 = !v6_q || m_axis_tready;
  assign rdy5 = !v5_q || rdy6;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign s_axis_tready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
      // only quads and bgr pixels make a result
      if (rdy6) v6_q <= v5_q && (p5_q.mode == MODE_QUAD || p5_q.mode == MODE_BGR);
    end
  end

  // stage 2: chroma products
  always_comb begin
    acc_t dcb, dcr;
    dcb = acc_t'($signed({2'b00, p1_q.chroma_blue}) - 10'sd128);
    dcr = acc_t'($signed({2'b00, p1_q.chroma_red}) - 10'sd128);
    k2_d.r_cr = acc_t'(K_R_CR * dcr);
    k2_d.g_cb = acc_t'(K_G_CB * dcb);
    k2_d.g_cr = acc_t'(K_G_CR * dcr);
    k2_d.b_cb = acc_t'(K_B_CB * dcb);
  end

  // stage 3: luma to rgb, clamp, curve read (bgr pixels index directly)
  assign ys2 = {p2_q.sample_d, p2_q.sample_c, p2_q.sample_b, p2_q.sample_a};
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      addr_r[l] = fix_u8(y_shift(ys2[l]) + k2_q.r_cr);
      addr_g[l] = fix_u8(y_shift(ys2[l]) - k2_q.g_cb - k2_q.g_cr);
      addr_b[l] = fix_u8(y_shift(ys2[l]) + k2_q.b_cb);
    end
    if (p2_q.mode == MODE_BGR) begin
      addr_r[0] = p2_q.sample_c;
      addr_g[0] = p2_q.sample_b;
      addr_b[0] = p2_q.sample_a;
    end
  end

  // curve writes go through the pipe so every copy sees them in item order
  assign luma_write = v2_q && rdy3 && (p2_q.mode == MODE_WRITE);
  assign avg_write  = v4_q && rdy5 && (p4_q.mode == MODE_WRITE);

  always_comb begin
    luma_wr_r = '{en: luma_write && p2_q.table_channel == CH_RED,
                  addr: p2_q.table_index, data: p2_q.sample_a};
    luma_wr_g = '{en: luma_write && p2_q.table_channel == CH_GREEN,
                  addr: p2_q.table_index, data: p2_q.sample_a};
    luma_wr_b = '{en: luma_write && p2_q.table_channel == CH_BLUE,
                  addr: p2_q.table_index, data: p2_q.sample_a};
    avg_wr_r  = '{en: avg_write && p4_q.table_channel == CH_RED,
                  addr: p4_q.table_index, data: p4_q.sample_a};
    avg_wr_g  = '{en: avg_write && p4_q.table_channel == CH_GREEN,
                  addr: p4_q.table_index, data: p4_q.sample_a};
    avg_wr_b  = '{en: avg_write && p4_q.table_channel == CH_BLUE,
                  addr: p4_q.table_index, data: p4_q.sample_a};
  end

  clr_curve_lut u_curve_r (
    .clk_i (clk_i), .luma_wr_i (luma_wr_r), .luma_re_i (rdy3),
    .luma_addr_i (addr_r), .luma_data_o (data_r), .avg_wr_i (avg_wr_r),
    .avg_re_i (rdy5), .avg_addr_i (avg_addr_r), .avg_data_o (avg_r)
  );
  clr_curve_lut u_curve_g (
    .clk_i (clk_i), .luma_wr_i (luma_wr_g), .luma_re_i (rdy3),
    .luma_addr_i (addr_g), .luma_data_o (data_g), .avg_wr_i (avg_wr_g),
    .avg_re_i (rdy5), .avg_addr_i (avg_addr_g), .avg_data_o (avg_g)
  );
  clr_curve_lut u_curve_b (
    .clk_i (clk_i), .luma_wr_i (luma_wr_b), .luma_re_i (rdy3),
    .luma_addr_i (addr_b), .luma_data_o (data_b), .avg_wr_i (avg_wr_b),
    .avg_re_i (rdy5), .avg_addr_i (avg_addr_b), .avg_data_o (avg_b)
  );

  // stage 4: curved rgb back to luma
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      y4_d[l] = fix_u8(mul_u8(K_Y_R, data_r[l]) + mul_u8(K_Y_G, data_g[l])
                       + mul_u8(K_Y_B, data_b[l]));
    end
  end

  // stage 5: average of corrected luma, to rgb, curve read
  assign ysum4 = 10'(y4_q[0]) + 10'(y4_q[1]) + 10'(y4_q[2]) + 10'(y4_q[3]);
  assign yavg4 = ysum4[9:2];
  assign avg_addr_r = fix_u8(y_shift(yavg4) + k4_q.r_cr);
  assign avg_addr_g = fix_u8(y_shift(yavg4) - k4_q.g_cb - k4_q.g_cr);
  assign avg_addr_b = fix_u8(y_shift(yavg4) + k4_q.b_cb);

  // stage 6: new chroma and output select
  assign cb_acc = K_128 - mul_u8(K_CB_R, avg_r) - mul_u8(K_CB_G, avg_g)
                  + mul_u8(K_HALF, avg_b);
  assign cr_acc = K_128 + mul_u8(K_HALF, avg_r) - mul_u8(K_CR_G, avg_g)
                  - mul_u8(K_CR_B, avg_b);

  always_comb begin
    case (p5_q.mode)
      MODE_QUAD: begin
        if (en_q) begin
          out_d = {fix_u8(cr_acc), fix_u8(cb_acc), y5_q[3], y5_q[2], y5_q[1], y5_q[0]};
        end else begin
          out_d = {p5_q.chroma_red, p5_q.chroma_blue, p5_q.sample_d,
                   p5_q.sample_c, p5_q.sample_b, p5_q.sample_a};
        end
      end
      MODE_BGR: begin
        if (en_q) begin
          out_d = {24'd0, bgr5_q[2], bgr5_q[1], bgr5_q[0]};
        end else begin
          out_d = {24'd0, p5_q.sample_c, p5_q.sample_b, p5_q.sample_a};
        end
      end
      default: out_d = '0;
    endcase
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (rdy1) p1_q <= in_w;
    if (rdy2) begin
      p2_q <= p1_q;
      k2_q <= k2_d;
    end
    if (rdy3) begin
      p3_q <= p2_q;
      k3_q <= k2_q;
    end
    if (rdy4) begin
      p4_q   <= p3_q;
      k4_q   <= k3_q;
      y4_q   <= y4_d;
      bgr4_q <= {data_r[0], data_g[0], data_b[0]};
    end
    if (rdy5) begin
      p5_q   <= p4_q;
      y5_q   <= y4_q;
      bgr5_q <= bgr4_q;
    end
    if (rdy6) out_q <= out_d;
  end

  assign m_axis_tvalid = v6_q;
  assign m_axis_tdata  = out_q;

  // an empty output stage never blocks the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v6_q |-> s_axis_tready) else $error("input stalled with empty output");

  // bgr results carry no fourth luma and no chroma
  a_bgr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rdy6 && v5_q && p5_q.mode == MODE_BGR) |=> (m_axis_tdata[47:24] == 24'd0))
    else $error("bgr result with nonzero upper fields");

  // a blocked stage holds its word
  a_stage5_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v5_q && !rdy5) |=> (v5_q && $stable(p5_q) && $stable(y5_q)))
    else $error("stage 5 word lost during stall");

  // curve writes never reach the output
  a_no_write_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rdy6 && v5_q && p5_q.mode == MODE_WRITE) |=> !v6_q)
    else $error("curve write produced a result");

endmodule

[hdl/clr_ram.sv]
// ----------------------------------------------------------------------------
// clr_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module clr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/clr_curve_lut.sv]
// ----------------------------------------------------------------------------
// clr_curve_lut
// one curve: four luma read copies and one copy for the averaged sample
// ----------------------------------------------------------------------------
module clr_curve_lut (
  input  logic                  clk_i,
  input  clr_pkg::curve_wr_t    luma_wr_i,
  input  logic                  luma_re_i,
  input  logic [3:0][7:0]       luma_addr_i,
  output logic [3:0][7:0]       luma_data_o,
  input  clr_pkg::curve_wr_t    avg_wr_i,
  input  logic                  avg_re_i,
  input  logic [7:0]            avg_addr_i,
  output logic [7:0]            avg_data_o
);
  import clr_pkg::*;

  for (genvar l = 0; l < 4; l++) begin : g_luma
    clr_ram #(.WIDTH(8), .DEPTH(CURVE_DEPTH)) u_ram (
      .clk_i   (clk_i),
      .we_i    (luma_wr_i.en),
      .waddr_i (luma_wr_i.addr),
      .wdata_i (luma_wr_i.data),
      .re_i    (luma_re_i),
      .raddr_i (luma_addr_i[l]),
      .rdata_o (luma_data_o[l])
    );
  end

  clr_ram #(.WIDTH(8), .DEPTH(CURVE_DEPTH)) u_avg_ram (
    .clk_i   (clk_i),
    .we_i    (avg_wr_i.en),
    .waddr_i (avg_wr_i.addr),
    .wdata_i (avg_wr_i.data),
    .re_i    (avg_re_i),
    .raddr_i (avg_addr_i),
    .rdata_o (avg_data_o)
  );

endmodule
